>>> rtl/pmkid_pkg.sv
// Shared types, constants and the microcode program of the station key table.
`timescale 1ns / 1ps
package pmkid_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W = 48;
  localparam int KEY_W = 64;
  localparam int ENTRY_W = ADDR_W + 2 * KEY_W;
  localparam int CFG_W = 6;
  localparam int HELD_W = 6;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int STEP_W = 4;

  localparam logic [CFG_W-1:0] MAX_RESET = CFG_W'(32);
  localparam logic PADDR_MAX_ENTRIES = 1'b0;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_ADDED     = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NO_SPACE  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NOSTART,
    C_IDX_EQ_CNT,
    C_MATCH,
    C_OP_REM,
    C_FULL,
    C_LAST
  } cond_e;

  localparam logic OP_SET = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_SRCH  = 4'd1;
  localparam step_t S_CMP   = 4'd2;
  localparam step_t S_NEXT  = 4'd3;
  localparam step_t S_FND   = 4'd4;
  localparam step_t S_UPD   = 4'd5;
  localparam step_t S_NF    = 4'd6;
  localparam step_t S_CHKSP = 4'd7;
  localparam step_t S_ADD   = 4'd8;
  localparam step_t S_NOSP  = 4'd9;
  localparam step_t S_NFR   = 4'd10;
  localparam step_t S_SH    = 4'd11;
  localparam step_t S_SHW   = 4'd12;
  localparam step_t S_RMV   = 4'd13;

  typedef struct packed {
    cond_e   cond;
    step_t   target;
    logic    rd_next;
    logic    wr_key;
    logic    wr_append;
    logic    wr_shift;
    logic    inc_idx;
    logic    inc_cnt;
    logic    dec_cnt;
    logic    done;
    status_e status;
  } ctl_t;

  function automatic ctl_t ucode(step_t s);
    ctl_t w;
    w.cond      = C_ALWAYS;
    w.target    = S_IDLE;
    w.rd_next   = 1'b0;
    w.wr_key    = 1'b0;
    w.wr_append = 1'b0;
    w.wr_shift  = 1'b0;
    w.inc_idx   = 1'b0;
    w.inc_cnt   = 1'b0;
    w.dec_cnt   = 1'b0;
    w.done      = 1'b0;
    w.status    = ST_UPDATED;
    case (s)
      S_IDLE: begin
        w.cond = C_NOSTART; w.target = S_IDLE;
      end
      S_SRCH: begin
        w.cond = C_IDX_EQ_CNT; w.target = S_NF;
      end
      S_CMP: begin
        w.cond = C_MATCH; w.target = S_FND;
      end
      S_NEXT: begin
        w.inc_idx = 1'b1; w.target = S_SRCH;
      end
      S_FND: begin
        w.cond = C_OP_REM; w.target = S_SH;
      end
      S_UPD: begin
        w.wr_key = 1'b1; w.done = 1'b1; w.status = ST_UPDATED;
      end
      S_NF: begin
        w.cond = C_OP_REM; w.target = S_NFR;
      end
      S_CHKSP: begin
        w.cond = C_FULL; w.target = S_NOSP;
      end
      S_ADD: begin
        w.wr_append = 1'b1; w.inc_cnt = 1'b1; w.done = 1'b1; w.status = ST_ADDED;
      end
      S_NOSP: begin
        w.done = 1'b1; w.status = ST_NO_SPACE;
      end
      S_NFR: begin
        w.done = 1'b1; w.status = ST_NOT_FOUND;
      end
      S_SH: begin
        w.cond = C_LAST; w.target = S_RMV; w.rd_next = 1'b1;
      end
      S_SHW: begin
        w.wr_shift = 1'b1; w.inc_idx = 1'b1; w.target = S_SH;
      end
      S_RMV: begin
        w.dec_cnt = 1'b1; w.done = 1'b1; w.status = ST_REMOVED;
      end
      default: begin
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/pmkid_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pmkid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pmkid_cache_table.sv
// Top level of the station address to key identifier table with a microcoded sequencer.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                 Payload
// request   in         start & !busy             opcode_i, station_addr_i,
//                                                key_id_high_i, key_id_low_i
// result    out        done_o (one-cycle strobe) status_o, entries_held_o
// config    in/out     psel & penable & pwrite   paddr, pwdata, prdata
//
// A request steps through the microcode: a search, a compare and a next step for each
// entry passed over, a read and a write step for each entry moved down on a remove, then
// the steps that finish it; done_o is registered from the last step. A set that misses
// the table, whether it adds or finds no space, is the longest request. The registered
// read of the table RAM puts a read step ahead of every compare and every move.
// Reset clears the count and sets the limit to 32; the table contents need no clearing.
// Results cannot be stalled; a new request may be taken while done_o is high.
module pmkid_cache_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              opcode_i,
  input  logic [pmkid_pkg::ADDR_W-1:0]      station_addr_i,
  input  logic [pmkid_pkg::KEY_W-1:0]       key_id_high_i,
  input  logic [pmkid_pkg::KEY_W-1:0]       key_id_low_i,
  output logic                              done_o,
  output logic [2:0]                        status_o,
  output logic [pmkid_pkg::HELD_W-1:0]      entries_held_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pmkid_pkg::PADDR_W-1:0]     paddr,
  input  logic [pmkid_pkg::PDATA_W-1:0]     pwdata,
  output logic [pmkid_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);

  localparam int CNT_W = pmkid_pkg::CNT_W;
  localparam int IDX_W = pmkid_pkg::IDX_W;

  pmkid_pkg::step_t                 step_q, step_d;
  pmkid_pkg::ctl_t                  ctl;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic [CNT_W-1:0]                 idx_q, idx_d;
  logic [CNT_W-1:0]                 idx_nx;
  logic [CNT_W-1:0]                 limit;
  logic [CNT_W-1:0]                 clamped;
  logic [pmkid_pkg::CFG_W-1:0]      max_q;
  logic                             done_q;
  pmkid_pkg::status_e               status_q;
  logic [pmkid_pkg::HELD_W-1:0]     held_q;
  logic                             op_q;
  logic [pmkid_pkg::ADDR_W-1:0]     addr_q;
  logic [pmkid_pkg::KEY_W-1:0]      khi_q;
  logic [pmkid_pkg::KEY_W-1:0]      klo_q;
  logic                             accept;
  logic                             taken;
  logic                             match;
  logic                             cfg_wr;
  logic                             ram_we;
  logic [IDX_W-1:0]                 ram_waddr;
  logic [IDX_W-1:0]                 ram_raddr;
  logic [pmkid_pkg::ENTRY_W-1:0]    ram_wdata;
  logic [pmkid_pkg::ENTRY_W-1:0]    ram_rdata;

  assign ctl    = pmkid_pkg::ucode(step_q);
  assign busy   = (step_q != pmkid_pkg::S_IDLE);
  assign accept = start && !busy;
  assign idx_nx = idx_q + CNT_W'(1);
  assign match  = (ram_rdata[pmkid_pkg::ENTRY_W-1 -: pmkid_pkg::ADDR_W] == addr_q);

  assign limit = (32'(max_q) > pmkid_pkg::MAX_ENTRIES) ? CNT_W'(pmkid_pkg::MAX_ENTRIES)
                                                        : CNT_W'(max_q);
  assign clamped = (cnt_q > limit) ? limit : cnt_q;

  always_comb begin
    case (ctl.cond)
      pmkid_pkg::C_ALWAYS:     taken = 1'b1;
      pmkid_pkg::C_NOSTART:    taken = !start;
      pmkid_pkg::C_IDX_EQ_CNT: taken = (idx_q == cnt_q);
      pmkid_pkg::C_MATCH:      taken = match;
      pmkid_pkg::C_OP_REM:     taken = (op_q == pmkid_pkg::OP_REMOVE);
      pmkid_pkg::C_FULL:       taken = (cnt_q >= limit);
      pmkid_pkg::C_LAST:       taken = (idx_nx >= cnt_q);
      default:                 taken = 1'b1;
    endcase
  end

  always_comb begin
    step_d = taken ? ctl.target : step_q + pmkid_pkg::step_t'(1);
    idx_d  = idx_q;
    cnt_d  = cnt_q;
    if (accept) begin
      idx_d = '0;
      cnt_d = clamped;
    end
    if (ctl.inc_idx) begin
      idx_d = idx_nx;
    end
    if (ctl.inc_cnt) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    if (ctl.dec_cnt) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  assign ram_we    = ctl.wr_key || ctl.wr_append || ctl.wr_shift;
  assign ram_waddr = ctl.wr_append ? cnt_q[IDX_W-1:0] : idx_q[IDX_W-1:0];
  assign ram_wdata = ctl.wr_shift ? ram_rdata : {addr_q, khi_q, klo_q};
  assign ram_raddr = ctl.rd_next ? idx_nx[IDX_W-1:0] : idx_q[IDX_W-1:0];

  pmkid_ram #(
    .WIDTH(pmkid_pkg::ENTRY_W),
    .DEPTH(pmkid_pkg::MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= pmkid_pkg::S_IDLE;
      cnt_q  <= '0;
      idx_q  <= '0;
      max_q  <= pmkid_pkg::MAX_RESET;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      done_q <= ctl.done;
      if (cfg_wr && (paddr[2] == pmkid_pkg::PADDR_MAX_ENTRIES) && (paddr[1:0] == 2'b00)) begin
        max_q <= pwdata[pmkid_pkg::CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      addr_q <= station_addr_i;
      khi_q  <= key_id_high_i;
      klo_q  <= key_id_low_i;
    end
    if (ctl.done) begin
      status_q <= ctl.status;
      held_q   <= pmkid_pkg::HELD_W'(cnt_d);
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign entries_held_o = held_q;
  assign pready         = 1'b1;
  assign prdata = (paddr == pmkid_pkg::PADDR_W'(0))
                ? pmkid_pkg::PDATA_W'(max_q) : '0;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(pmkid_pkg::MAX_ENTRIES))
    else $error("entry count above capacity");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("request taken without going busy");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer still running");

  a_add_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == pmkid_pkg::ST_ADDED) |-> (entries_held_o != '0))
    else $error("add left table empty");

endmodule

>>> sim/pmkid_cache_table_test.sv
// Self-checking testbench of the station address to key identifier table.
`timescale 1ns / 1ps
module pmkid_cache_table_test;
  import pmkid_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int POOL_SIZE = 40;
  localparam int PHASES = 8;
  localparam logic [PADDR_W-1:0] LIMIT_REG_ADDR = PADDR_W'(4 * PADDR_MAX_ENTRIES);
  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
  localparam logic [KEY_W-1:0] KEY_ONES = '1;

  typedef struct {
    status_e           status;
    logic [HELD_W-1:0] held;
  } outcome_t;

  class key_table_scoreboard;
    logic [ADDR_W-1:0] addr_tab [MAX_ENTRIES];
    int unsigned       held_count;
    int unsigned       limit_reg;
    outcome_t          pending_q [$];
    int                errors;

    function new();
      held_count = 0;
      limit_reg = MAX_RESET;
      errors = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void set_limit(logic [CFG_W-1:0] value);
      limit_reg = value;
    endfunction

    function void note_request(logic op, logic [ADDR_W-1:0] addr);
      int unsigned lim;
      int unsigned cnt;
      int          hit;
      outcome_t    o;
      lim = (limit_reg > MAX_ENTRIES) ? MAX_ENTRIES : limit_reg;
      cnt = (held_count > lim) ? lim : held_count;
      hit = -1;
      for (int i = 0; i < cnt; i++) begin
        if (hit < 0 && addr_tab[i] == addr) hit = i;
      end
      if (op == OP_SET) begin
        if (hit >= 0) begin
          o.status = ST_UPDATED;
        end else if (cnt >= lim) begin
          o.status = ST_NO_SPACE;
        end else begin
          addr_tab[cnt] = addr;
          cnt++;
          o.status = ST_ADDED;
        end
      end else if (hit >= 0) begin
        for (int i = hit; i + 1 < cnt; i++) addr_tab[i] = addr_tab[i + 1];
        cnt--;
        o.status = ST_REMOVED;
      end else begin
        o.status = ST_NOT_FOUND;
      end
      held_count = cnt;
      o.held = HELD_W'(cnt);
      pending_q.push_back(o);
    endfunction

    function void check_result(logic [2:0] status, logic [HELD_W-1:0] held);
      outcome_t o;
      if (pending_q.size() == 0) begin
        report($sformatf("result with no request: status %0d held %0d", status, held));
        return;
      end
      o = pending_q.pop_front();
      if (status !== o.status)
        report($sformatf("status %0d, expected %s", status, o.status.name()));
      if (held !== o.held)
        report($sformatf("entries_held %0d, expected %0d", held, o.held));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                opcode_i;
  logic [ADDR_W-1:0]   station_addr_i;
  logic [KEY_W-1:0]    key_id_high_i;
  logic [KEY_W-1:0]    key_id_low_i;
  logic                done_o;
  logic [2:0]          status_o;
  logic [HELD_W-1:0]   entries_held_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  key_table_scoreboard sb;
  logic [ADDR_W-1:0]   station_pool [POOL_SIZE];
  bit                  quiet;
  int unsigned         cycle_count = 0;
  int unsigned         phase_limit [PHASES] = '{32, 63, 5, 1, 0, 33, 20, 32};
  int unsigned         phase_set_pct [PHASES] = '{85, 60, 70, 60, 50, 85, 55, 30};
  int unsigned         phase_items [PHASES] = '{100, 90, 90, 70, 30, 110, 110, 100};

  pmkid_cache_table DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .station_addr_i (station_addr_i),
    .key_id_high_i  (key_id_high_i),
    .key_id_low_i   (key_id_low_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .entries_held_o (entries_held_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pmkid_cache_table_test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(status_o, entries_held_o);
  end

  task automatic send_request(input logic op, input logic [ADDR_W-1:0] addr,
                              input logic [KEY_W-1:0] khi, input logic [KEY_W-1:0] klo);
    if (!quiet && $urandom_range(99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(40, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= op;
    station_addr_i <= addr;
    key_id_high_i <= khi;
    key_id_low_i <= klo;
    do @(posedge clk_i); while (busy);
    sb.note_request(op, addr);
  endtask

  task automatic settle_requests();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] value);
    logic [PDATA_W-1:0] noise;
    noise = $urandom;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LIMIT_REG_ADDR;
    pwdata <= {noise[PDATA_W-1:CFG_W], value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_limit(value);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CFG_W-1:0] !== value)
      sb.report($sformatf("max_entries reads %0d, expected %0d", prdata[CFG_W-1:0], value));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5) return '0;
    if (sel < 10) return KEY_ONES;
    return {$urandom, $urandom};
  endfunction

  task automatic random_request(input int unsigned set_pct);
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [63:0]       r64;
    int unsigned       sel;
    op = ($urandom_range(99) < set_pct) ? OP_SET : OP_REMOVE;
    sel = $urandom_range(99);
    r64 = {$urandom, $urandom};
    if (sel < 75) addr = station_pool[$urandom_range(POOL_SIZE - 1)];
    else if (sel < 85)
      addr = station_pool[$urandom_range(POOL_SIZE - 1)] ^ (ADDR_W'(1) << $urandom_range(47));
    else addr = r64[ADDR_W-1:0];
    send_request(op, addr, random_key(), random_key());
  endtask

  initial begin
    logic [63:0] r64;
    rst_ni <= 1'b0;
    start <= 1'b0;
    opcode_i <= OP_SET;
    station_addr_i <= '0;
    key_id_high_i <= '0;
    key_id_low_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    quiet = 1'b0;
    sb = new();
    station_pool[0] = '0;
    station_pool[1] = ADDR_ONES;
    for (int i = 2; i < POOL_SIZE; i++) begin
      r64 = {$urandom, $urandom};
      station_pool[i] = r64[ADDR_W-1:0];
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, reset limit, update, near-miss address, removes with compaction
    send_request(OP_REMOVE, '0, '0, '0);
    send_request(OP_SET, '0, '0, '0);
    send_request(OP_SET, ADDR_ONES, KEY_ONES, KEY_ONES);
    send_request(OP_SET, '0, KEY_ONES, KEY_ONES);
    send_request(OP_SET, ADDR_W'(1), random_key(), random_key());
    send_request(OP_REMOVE, ADDR_ONES, KEY_ONES, '0);
    send_request(OP_REMOVE, ADDR_ONES, '0, KEY_ONES);
    send_request(OP_SET, ADDR_W'(2), random_key(), random_key());
    send_request(OP_REMOVE, '0, random_key(), random_key());
    settle_requests();

    // full table, then clamping below the held count
    write_limit(CFG_W'(2));
    send_request(OP_SET, ADDR_W'(3), random_key(), random_key());
    send_request(OP_SET, ADDR_W'(1), random_key(), random_key());
    settle_requests();
    write_limit(CFG_W'(1));
    send_request(OP_SET, ADDR_W'(2), random_key(), random_key());
    send_request(OP_REMOVE, ADDR_W'(2), random_key(), random_key());
    settle_requests();

    // zero limit, then a limit above capacity
    write_limit(CFG_W'(0));
    send_request(OP_SET, ADDR_W'(1), random_key(), random_key());
    send_request(OP_REMOVE, ADDR_W'(1), random_key(), random_key());
    settle_requests();
    write_limit(CFG_W'(63));
    send_request(OP_SET, ADDR_W'(1), random_key(), random_key());
    send_request(OP_SET, station_pool[5], random_key(), random_key());
    send_request(OP_SET, ADDR_ONES, random_key(), random_key());
    send_request(OP_REMOVE, ADDR_ONES, random_key(), random_key());
    settle_requests();

    for (int ph = 0; ph < PHASES; ph++) begin
      quiet = (ph == 1);
      if (ph == 6) write_limit(CFG_W'($urandom_range(63)));
      else write_limit(CFG_W'(phase_limit[ph]));
      for (int n = 0; n < phase_items[ph]; n++) random_request(phase_set_pct[ph]);
      settle_requests();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("pmkid_cache_table_test passed");
    end else begin
      $display("pmkid_cache_table_test failed");
    end
    $finish;
  end

endmodule

>>> pmkid_cache_table.f
rtl/pmkid_pkg.sv
rtl/pmkid_ram.sv
rtl/pmkid_cache_table.sv
sim/pmkid_cache_table_test.sv
